// ===== rtl/nalf_pkg.sv =====
// ----------------------------------------------------------------------------
// nalf_pkg
// Shared types and constants for the NAL unit to Annex B byte stream framer.
// ----------------------------------------------------------------------------
package nalf_pkg;

  localparam int MAX_PARAM_SET_BYTES = 256;
  localparam int PCOUNT_W = $clog2(MAX_PARAM_SET_BYTES + 2);
  localparam int ADDR_W = $clog2(MAX_PARAM_SET_BYTES);
  localparam logic [PCOUNT_W-1:0] PARAM_MAX = PCOUNT_W'(MAX_PARAM_SET_BYTES);

  localparam int LOOKAHEAD = 4;
  localparam logic [2:0] LA_FULL = 3'(LOOKAHEAD);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] TYPE_MASK = 8'((1 << 5) - 1);
  localparam logic [4:0] NAL_SPS = 5'd7;
  localparam logic [4:0] NAL_PPS = 5'd8;

  localparam logic [7:0] ESC_BYTE = 8'h03;
  localparam logic [7:0] START_ONE = 8'h01;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  // Start code lengths carried with each request.
  localparam logic [2:0] START_NONE = 3'd0;
  localparam logic [2:0] START_SHORT = 3'd3;
  localparam logic [2:0] START_LONG = 3'd4;

  // Position within a NAL: idle, one to three bytes held, or streaming.
  localparam logic [2:0] POS_IDLE = 3'd0;
  localparam logic [2:0] POS_STREAM = 3'd5;

  // One request from the classifier to the serialiser.
  typedef struct packed {
    logic [LOOKAHEAD-1:0][7:0] data;
    logic [LOOKAHEAD-1:0]      esc;
    logic [2:0]                cnt;
    logic [2:0]                sc_len;
    logic                      fin;
    logic                      changed;
  } cmd_t;

endpackage

// ===== rtl/nal_to_annexb_framer.sv =====
// ----------------------------------------------------------------------------
// nal_to_annexb_framer
// Turns NAL unit bytes into an Annex B byte stream with start codes and
// emulation prevention bytes, and flags changed SPS/PPS contents.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+---------------------------------------------
//  input   | in_valid / in_ready  | in_byte, nal_first, nal_final, picture_first
//  output  | out_valid / out_ready| out_byte, nal_done, param_changed, run_last
//
// Output runs at one byte per cycle while a request waits and out_ready is high;
// an input byte is taken every cycle while the four-entry queue has room.
// A byte that completes the four held header bytes yields up to nine output
// bytes; a streamed body byte yields one, or two with an escape byte.
// Reset is synchronous and needs no clearing pass; data read from the parameter
// set stores is compared only below the stored length of a valid copy.
// A stalled output fills the queue and then holds in_ready low.
// ----------------------------------------------------------------------------
module nal_to_annexb_framer import nalf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       nal_first,
  input  logic       nal_final,
  input  logic       picture_first,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       nal_done,
  output logic       param_changed,
  output logic       run_last
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_in;
  cmd_t q_head;

  nalf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .nal_first     (nal_first),
    .nal_final     (nal_final),
    .picture_first (picture_first),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_in)
  );

  nalf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  nalf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .empty         (q_empty),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .nal_done      (nal_done),
    .param_changed (param_changed),
    .run_last      (run_last)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("request pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("request popped from an empty queue");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (nal_done || param_changed) |-> run_last)
    else $error("NAL end marked on a byte that is not the last of its request");

  a_ready_with_room: assert property (@(posedge clk) disable iff (rst)
    !q_full |-> in_ready)
    else $error("input stalled while the queue has room");

endmodule

// ===== rtl/nalf_queue.sv =====
// ----------------------------------------------------------------------------
// nalf_queue
// Short request queue between the classifier and the serialiser.
// ----------------------------------------------------------------------------
module nalf_queue import nalf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign head  = entry[rd_ptr];
  assign full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/nalf_front.sv =====
// ----------------------------------------------------------------------------
// nalf_front
// Accepts NAL bytes, holds the first four, decides on verbatim copy or start
// code, works out escape insertions and tracks the parameter set copies.
// ----------------------------------------------------------------------------
module nalf_front import nalf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       nal_first,
  input  logic       nal_final,
  input  logic       picture_first,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  function automatic logic is_param(input logic [4:0] t);
    is_param = (t == NAL_SPS) || (t == NAL_PPS);
  endfunction

  // Input stage: byte index and type tracking, store access.
  logic                accept;
  logic                advance;
  logic                a_valid;
  logic [7:0]          a_byte;
  logic                a_first;
  logic                a_fin;
  logic                a_pic;
  logic                a_open;
  logic [PCOUNT_W-1:0] a_idx;
  logic [4:0]          a_type;
  logic                new_nal;
  logic [PCOUNT_W-1:0] idx_cur;
  logic [4:0]          type_cur;
  logic                wr_en;
  logic [ADDR_W-1:0]   addr;
  logic [7:0]          sps_mem [MAX_PARAM_SET_BYTES];
  logic [7:0]          pps_mem [MAX_PARAM_SET_BYTES];
  logic [7:0]          sps_rd;
  logic [7:0]          pps_rd;

  assign in_ready = !a_valid || !q_full;
  assign accept   = in_valid && in_ready;
  assign advance  = a_valid && !q_full;

  assign new_nal  = nal_first || !a_open;
  assign idx_cur  = new_nal ? '0 : ((a_idx == PARAM_MAX) ? a_idx : a_idx + 1'b1);
  assign type_cur = new_nal ? 5'(in_byte & TYPE_MASK) : a_type;
  assign addr     = idx_cur[ADDR_W-1:0];
  // The first four bytes live in flip-flops until the NAL is decided.
  assign wr_en    = accept && is_param(type_cur) &&
                    (idx_cur >= PCOUNT_W'(LOOKAHEAD)) && (idx_cur < PARAM_MAX);

  always_ff @(posedge clk) begin
    if (accept) begin
      sps_rd <= sps_mem[addr];
      if (wr_en && (type_cur == NAL_SPS)) begin
        sps_mem[addr] <= in_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pps_rd <= pps_mem[addr];
      if (wr_en && (type_cur == NAL_PPS)) begin
        pps_mem[addr] <= in_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_byte  <= in_byte;
      a_first <= nal_first;
      a_fin   <= nal_final;
      a_pic   <= picture_first;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_open  <= 1'b0;
      a_idx   <= '0;
      a_type  <= '0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
        a_open  <= !nal_final;
        a_idx   <= idx_cur;
        a_type  <= type_cur;
      end else if (advance) begin
        a_valid <= 1'b0;
      end
    end
  end

  // Classification stage.
  logic [LOOKAHEAD-1:0][7:0] la, la_next;
  logic [LOOKAHEAD-1:0][7:0] sps_head, sps_head_next;
  logic [LOOKAHEAD-1:0][7:0] pps_head, pps_head_next;
  logic [2:0]                la_cnt, la_cnt_next;
  logic [2:0]                pos, pos_next;
  logic                      verb, verb_next;
  logic                      gsp, gsp_next;
  logic [4:0]                ntype, ntype_next;
  logic [1:0]                zrun, zrun_next;
  logic [PCOUNT_W-1:0]       pcount, pcount_next;
  logic                      mism, mism_next;
  logic [PCOUNT_W-1:0]       sps_len, sps_len_next;
  logic [PCOUNT_W-1:0]       pps_len, pps_len_next;
  logic                      sps_v, sps_v_next;
  logic                      pps_v, pps_v_next;
  logic                      push_cmd;
  cmd_t                      cmd;

  always_comb begin
    logic       fin_k;
    logic       esc;
    logic       changed;
    logic [7:0] rd;
    la_next       = la;
    sps_head_next = sps_head;
    pps_head_next = pps_head;
    la_cnt_next   = la_cnt;
    pos_next      = pos;
    verb_next     = verb;
    gsp_next      = gsp;
    ntype_next    = ntype;
    zrun_next     = zrun;
    pcount_next   = pcount;
    mism_next     = mism;
    sps_len_next  = sps_len;
    pps_len_next  = pps_len;
    sps_v_next    = sps_v;
    pps_v_next    = pps_v;
    push_cmd      = 1'b0;
    cmd           = '0;
    changed       = 1'b0;
    fin_k         = 1'b0;
    esc           = 1'b0;
    rd            = (ntype == NAL_PPS) ? pps_rd : sps_rd;

    // A new NAL inside an open one drops the old one.
    if (a_first && (pos != POS_IDLE)) begin
      if ((pos == POS_STREAM) && !verb) begin
        if (ntype == NAL_SPS) sps_v_next = 1'b0;
        if (ntype == NAL_PPS) pps_v_next = 1'b0;
      end
      pos_next    = POS_IDLE;
      la_cnt_next = '0;
      verb_next   = 1'b0;
    end
    if (pos_next == POS_IDLE) begin
      if (a_pic) gsp_next = 1'b1;
      la_cnt_next = '0;
      verb_next   = 1'b0;
    end

    if (pos_next != POS_STREAM) begin
      la_next[la_cnt_next[1:0]] = a_byte;
      la_cnt_next = la_cnt_next + 1'b1;
      pos_next    = la_cnt_next;
      if ((la_cnt_next == LA_FULL) || a_fin) begin
        push_cmd = 1'b1;
        cmd.cnt  = la_cnt_next;
        cmd.data = la_next;
        if ((la_cnt_next == LA_FULL) && (la_next[0] == ZERO_BYTE) &&
            (la_next[1] == ZERO_BYTE) && (la_next[2] == ZERO_BYTE) &&
            (la_next[3] == START_ONE)) begin
          verb_next  = 1'b1;
          cmd.sc_len = START_NONE;
        end else begin
          verb_next  = 1'b0;
          ntype_next = 5'(la_next[0] & TYPE_MASK);
          cmd.sc_len = (gsp_next || is_param(ntype_next)) ? START_LONG : START_SHORT;
          gsp_next   = 1'b0;
          mism_next  = 1'b0;
          zrun_next  = '0;
          pcount_next = is_param(ntype_next) ? PCOUNT_W'(la_cnt_next) : '0;
          for (int k = 0; k < LOOKAHEAD; k++) begin
            if (3'(k) < la_cnt_next) begin
              if (ntype_next == NAL_SPS) begin
                if (sps_v_next && (PCOUNT_W'(k) < sps_len_next) &&
                    (sps_head[k] != la_next[k])) begin
                  mism_next = 1'b1;
                end
                sps_head_next[k] = la_next[k];
              end
              if (ntype_next == NAL_PPS) begin
                if (pps_v_next && (PCOUNT_W'(k) < pps_len_next) &&
                    (pps_head[k] != la_next[k])) begin
                  mism_next = 1'b1;
                end
                pps_head_next[k] = la_next[k];
              end
              if (k > 0) begin
                fin_k = a_fin && (3'(k + 1) == la_cnt_next);
                esc   = (zrun_next == 2'd2) && (la_next[k] <= ESC_BYTE) && !fin_k;
                if (esc) zrun_next = '0;
                cmd.esc[k] = esc;
                if (la_next[k] == ZERO_BYTE) begin
                  zrun_next = (zrun_next == 2'd2) ? 2'd2 : zrun_next + 1'b1;
                end else begin
                  zrun_next = '0;
                end
              end
            end
          end
        end
        la_cnt_next = '0;
        pos_next    = POS_STREAM;
      end
    end else if (verb_next) begin
      push_cmd    = 1'b1;
      cmd.cnt     = 3'd1;
      cmd.data[0] = a_byte;
      cmd.sc_len  = START_NONE;
    end else begin
      push_cmd    = 1'b1;
      cmd.cnt     = 3'd1;
      cmd.data[0] = a_byte;
      cmd.sc_len  = START_NONE;
      if (is_param(ntype_next)) begin
        if (pcount_next < PARAM_MAX) begin
          if ((ntype_next == NAL_SPS) && sps_v_next && (pcount_next < sps_len_next) &&
              (rd != a_byte)) begin
            mism_next = 1'b1;
          end
          if ((ntype_next == NAL_PPS) && pps_v_next && (pcount_next < pps_len_next) &&
              (rd != a_byte)) begin
            mism_next = 1'b1;
          end
        end
        if (pcount_next <= PARAM_MAX) pcount_next = pcount_next + 1'b1;
      end
      esc = (zrun_next == 2'd2) && (a_byte <= ESC_BYTE) && !a_fin;
      if (esc) zrun_next = '0;
      cmd.esc[0] = esc;
      if (a_byte == ZERO_BYTE) begin
        zrun_next = (zrun_next == 2'd2) ? 2'd2 : zrun_next + 1'b1;
      end else begin
        zrun_next = '0;
      end
    end

    if (a_fin) begin
      if (!verb_next) begin
        if (ntype_next == NAL_SPS) begin
          if (pcount_next > PARAM_MAX) begin
            changed      = 1'b1;
            sps_v_next   = 1'b0;
            sps_len_next = '0;
          end else begin
            changed      = sps_v_next && (mism_next || (pcount_next != sps_len_next));
            sps_len_next = pcount_next;
            sps_v_next   = 1'b1;
          end
          // A changed sequence set makes the stored picture set stale.
          if (changed) pps_v_next = 1'b0;
        end
        if (ntype_next == NAL_PPS) begin
          if (pcount_next > PARAM_MAX) begin
            changed      = 1'b1;
            pps_v_next   = 1'b0;
            pps_len_next = '0;
          end else begin
            changed      = pps_v_next && (mism_next || (pcount_next != pps_len_next));
            pps_len_next = pcount_next;
            pps_v_next   = 1'b1;
          end
        end
      end
      pos_next    = POS_IDLE;
      la_cnt_next = '0;
      verb_next   = 1'b0;
      cmd.fin     = 1'b1;
      cmd.changed = changed;
    end
  end

  assign q_push = advance && push_cmd;
  assign q_cmd  = cmd;

  always_ff @(posedge clk) begin
    if (advance) begin
      la       <= la_next;
      sps_head <= sps_head_next;
      pps_head <= pps_head_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      la_cnt  <= '0;
      pos     <= POS_IDLE;
      verb    <= 1'b0;
      gsp     <= 1'b1;
      ntype   <= '0;
      zrun    <= '0;
      pcount  <= '0;
      mism    <= 1'b0;
      sps_len <= '0;
      pps_len <= '0;
      sps_v   <= 1'b0;
      pps_v   <= 1'b0;
    end else if (advance) begin
      la_cnt  <= la_cnt_next;
      pos     <= pos_next;
      verb    <= verb_next;
      gsp     <= gsp_next;
      ntype   <= ntype_next;
      zrun    <= zrun_next;
      pcount  <= pcount_next;
      mism    <= mism_next;
      sps_len <= sps_len_next;
      pps_len <= pps_len_next;
      sps_v   <= sps_v_next;
      pps_v   <= pps_v_next;
    end
  end

endmodule

// ===== rtl/nalf_back.sv =====
// ----------------------------------------------------------------------------
// nalf_back
// Serialises queued requests into output bytes: start code, escape bytes and
// data, one byte per cycle into a registered output while out_ready allows.
// ----------------------------------------------------------------------------
module nalf_back import nalf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       nal_done,
  output logic       param_changed,
  output logic       run_last
);

  logic [2:0] sc_cnt;
  logic [1:0] k;
  logic       esc_sent;
  logic       in_sc;
  logic       in_esc;
  logic       cur_last;
  logic [7:0] cur_byte;
  logic       load;

  always_comb begin
    in_sc    = (sc_cnt < head.sc_len);
    in_esc   = 1'b0;
    cur_last = 1'b0;
    if (in_sc) begin
      cur_byte = (sc_cnt == head.sc_len - 3'd1) ? START_ONE : ZERO_BYTE;
    end else if (head.esc[k] && !esc_sent) begin
      in_esc   = 1'b1;
      cur_byte = ESC_BYTE;
    end else begin
      cur_byte = head.data[k];
      cur_last = ((3'(k) + 3'd1) == head.cnt);
    end
  end

  assign load = !empty && (!out_valid || out_ready);
  assign pop  = load && cur_last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= cur_byte;
      nal_done      <= cur_last && head.fin;
      param_changed <= cur_last && head.fin && head.changed;
      run_last      <= cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sc_cnt    <= '0;
      k         <= '0;
      esc_sent  <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        if (in_sc) begin
          sc_cnt <= sc_cnt + 1'b1;
        end else if (in_esc) begin
          esc_sent <= 1'b1;
        end else if (cur_last) begin
          sc_cnt   <= '0;
          k        <= '0;
          esc_sent <= 1'b0;
        end else begin
          k        <= k + 1'b1;
          esc_sent <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
